// File: design/cooling_capacity_governor_assert.svh
// Assertion macros for the cooling capacity governor.
`ifndef COOLING_CAPACITY_GOVERNOR_ASSERT_SVH
`define COOLING_CAPACITY_GOVERNOR_ASSERT_SVH

// Checked only while out of reset.
`define CCG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CCG_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ccg_pkg.sv
// Types, constants and helpers shared by the cooling capacity governor.
package ccg_pkg;

    typedef struct packed {
        logic               soft_reset;
        logic signed [15:0] temp_error;
        logic signed [15:0] temperature;
        logic [15:0]        elapsed;
        logic [9:0]         fan_now;
        logic [9:0]         fan_target;
        logic [15:0]        capacity_in;
        logic [9:0]         compressor_freq;
    } in_item_t;

    typedef struct packed {
        logic [10:0] fan_out;
        logic [21:0] capacity_out_x40;
        logic [1:0]  mode_out;
    } out_item_t;

    typedef struct packed {
        logic [15:0] speed_period;
        logic [15:0] factor_period;
        logic [9:0]  freq_limit;
    } cfg_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_STABLE = 3'b010,
        MODE_CHANGE = 3'b100
    } mode_t;

    typedef enum logic [1:0] {
        TREND_NONE = 2'd0,
        TREND_UP   = 2'd1,
        TREND_DOWN = 2'd2
    } trend_t;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_SPEED_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_FACTOR_PERIOD = 2'd1;
    localparam logic [1:0] CFG_FREQ_LIMIT    = 2'd2;

    localparam logic [15:0] SPEED_PERIOD_RST  = 16'd120;
    localparam logic [15:0] FACTOR_PERIOD_RST = 16'd300;
    localparam logic [9:0]  FREQ_LIMIT_RST    = 10'd60;

    // Mode codes as reported on mode_out
    localparam logic [1:0] MODE_CODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_CODE_STABLE = 2'd1;
    localparam logic [1:0] MODE_CODE_CHANGE = 2'd2;

    // Temperature error thresholds
    localparam logic signed [15:0] TE_CHANGE  = 16'sd10;
    localparam logic signed [15:0] TE_SETTLED = 16'sd5;
    localparam logic signed [15:0] TE_COLD    = 16'sd1;
    localparam logic signed [15:0] TE_FAST    = 16'sd30;
    localparam logic signed [15:0] TE_BAND4   = 16'sd60;
    localparam logic signed [15:0] TE_BAND3   = 16'sd45;
    localparam logic signed [15:0] TE_BAND2   = 16'sd30;
    localparam logic signed [15:0] TE_BAND1   = 16'sd15;

    localparam logic [10:0] BOOST4 = 11'd40;
    localparam logic [10:0] BOOST3 = 11'd30;
    localparam logic [10:0] BOOST2 = 11'd20;
    localparam logic [10:0] BOOST1 = 11'd10;

    localparam logic signed [16:0] DROP_BIG   = 17'sd10;
    localparam logic signed [16:0] DROP_SMALL = 17'sd5;

    // Capacity factor in 0.025 steps: 40 is unity
    localparam logic [5:0] CAP_UNITY       = 6'd40;
    localparam logic [5:0] CAP_CHANGE_INIT = 6'd36;
    localparam logic [2:0] ALPHA_INIT      = 3'd4;
    localparam logic signed [3:0] ALPHA_TOP_LOWER = 4'sd4;
    localparam logic signed [3:0] ALPHA_TOP_RAISE = 4'sd2;
    localparam logic [3:0] BETA_MAX        = 4'd8;
    localparam logic [31:0] SPEED_START    = 32'd60;

    localparam logic signed [47:0] DELTA_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] DELTA_MIN = {1'b1, {47{1'b0}}};

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// File: design/ccg_core.sv
// Governor state and the combinational next-state and result logic.
module ccg_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  ccg_pkg::in_item_t item,
    input  ccg_pkg::cfg_t    cfg,
    output ccg_pkg::out_item_t result
);

    ccg_pkg::mode_t    mode_reg, mode_next;
    ccg_pkg::trend_t   trend_reg, trend_next;
    logic              raising_reg, raising_next;
    logic [1:0]        osc_reg, osc_next;
    logic              watch_reg, watch_next;
    logic              long_reg, long_next;
    logic [31:0]       period_timer_reg, period_timer_next;
    logic [31:0]       speed_timer_reg, speed_timer_next;
    logic signed [15:0] window_reg, window_next;
    logic [2:0]        alpha_reg, alpha_next;
    logic [3:0]        beta_reg, beta_next;
    logic signed [47:0] delta_reg, delta_next;
    logic [10:0]       fan_hold_reg, fan_hold_next;
    logic [21:0]       cap_hold_reg, cap_hold_next;

    logic               te_high, te_settled, delta_le0;
    logic [15:0]        period_sel;
    logic               stable_hit, speed_hit, factor_hit;
    logic [3:0]         beta_settle, beta_up, beta_dn;
    logic [1:0]         osc_inc;
    logic [10:0]        fan_boost;
    logic signed [16:0] drop, need;
    logic signed [3:0]  alpha_sum, alpha_top;
    logic [2:0]         alpha_adj, alpha_use;
    logic               raise_new;
    logic [5:0]         cap_factor;
    logic [21:0]        cap_prod;
    logic [18:0]        alpha_prod;
    logic signed [48:0] delta_sum;
    logic signed [47:0] delta_sat;

    assign te_high    = item.temp_error > ccg_pkg::TE_CHANGE;
    assign te_settled = item.temp_error <= ccg_pkg::TE_SETTLED;
    assign delta_le0  = delta_reg[47] || (delta_reg == '0);

    assign period_sel = long_reg ? cfg.factor_period : cfg.speed_period;
    assign stable_hit = period_timer_reg >= {16'd0, period_sel};
    assign speed_hit  = speed_timer_reg >= {16'd0, cfg.speed_period};
    assign factor_hit = period_timer_reg >= {16'd0, cfg.factor_period};

    assign beta_settle = te_settled ? 4'd1 : 4'd0;
    assign beta_up     = (beta_reg < ccg_pkg::BETA_MAX) ? beta_reg + 4'd1 : beta_reg;
    assign beta_dn     = (beta_reg >= 4'd2) ? beta_reg - 4'd2 : 4'd0;
    assign osc_inc     = osc_reg + 2'd1;

    always_comb
    begin
        priority if (item.temp_error > ccg_pkg::TE_BAND4)
            fan_boost = {1'b0, item.fan_target} + ccg_pkg::BOOST4;
        else if (item.temp_error > ccg_pkg::TE_BAND3)
            fan_boost = {1'b0, item.fan_target} + ccg_pkg::BOOST3;
        else if (item.temp_error > ccg_pkg::TE_BAND2)
            fan_boost = {1'b0, item.fan_target} + ccg_pkg::BOOST2;
        else if (item.temp_error > ccg_pkg::TE_BAND1)
            fan_boost = {1'b0, item.fan_target} + ccg_pkg::BOOST1;
        else
            fan_boost = {1'b0, item.fan_target};
    end

    // Direction update in the regular change-mode step
    always_comb
    begin
        raise_new = raising_reg;
        if (raising_reg && (item.compressor_freq > cfg.freq_limit))
            raise_new = 1'b0;
        else if (!raising_reg && (item.compressor_freq <= cfg.freq_limit) && !delta_le0)
            raise_new = 1'b1;
    end

    assign drop      = {window_reg[15], window_reg} - {item.temperature[15], item.temperature};
    assign need      = (item.temp_error > ccg_pkg::TE_FAST) ? ccg_pkg::DROP_BIG
                                                            : ccg_pkg::DROP_SMALL;
    assign alpha_sum = $signed({1'b0, alpha_reg}) + ((drop >= need) ? 4'sd1 : -4'sd1);
    assign alpha_top = raise_new ? ccg_pkg::ALPHA_TOP_RAISE : ccg_pkg::ALPHA_TOP_LOWER;

    always_comb
    begin
        priority if (alpha_sum > alpha_top)
            alpha_adj = alpha_top[2:0];
        else if (alpha_sum < 4'sd0)
            alpha_adj = 3'd0;
        else
            alpha_adj = alpha_sum[2:0];
    end

    assign alpha_use  = factor_hit ? alpha_adj : alpha_reg;
    assign alpha_prod = 19'(alpha_use) * 19'(item.capacity_in);
    assign delta_sum  = raise_new ? {delta_reg[47], delta_reg} - {30'd0, alpha_prod}
                                  : {delta_reg[47], delta_reg} + {30'd0, alpha_prod};
    assign delta_sat  = (delta_sum[48] != delta_sum[47])
                      ? (delta_sum[48] ? ccg_pkg::DELTA_MIN : ccg_pkg::DELTA_MAX)
                      : delta_sum[47:0];

    assign cap_prod = 22'(cap_factor) * 22'(item.capacity_in);

    always_comb
    begin
        mode_next         = mode_reg;
        trend_next        = trend_reg;
        raising_next      = raising_reg;
        osc_next          = osc_reg;
        watch_next        = watch_reg;
        long_next         = long_reg;
        period_timer_next = period_timer_reg;
        speed_timer_next  = speed_timer_reg;
        window_next       = window_reg;
        alpha_next        = alpha_reg;
        beta_next         = beta_reg;
        delta_next        = delta_reg;
        fan_hold_next     = fan_hold_reg;
        cap_factor        = ccg_pkg::CAP_UNITY;
        cap_hold_next     = cap_prod;

        if (item.soft_reset)
        begin
            mode_next         = ccg_pkg::MODE_IDLE;
            trend_next        = ccg_pkg::TREND_NONE;
            osc_next          = 2'd0;
            watch_next        = 1'b0;
            long_next         = 1'b0;
            period_timer_next = '0;
            speed_timer_next  = '0;
            window_next       = '0;
            alpha_next        = ccg_pkg::ALPHA_INIT;
            beta_next         = '0;
            delta_next        = '0;
            fan_hold_next     = '0;
            cap_hold_next     = cap_hold_reg;
        end
        else
        begin
            unique case (mode_reg)
                ccg_pkg::MODE_IDLE,
                ccg_pkg::MODE_STABLE:
                begin
                    if (te_high)
                    begin
                        mode_next         = ccg_pkg::MODE_CHANGE;
                        raising_next      = 1'b0;
                        alpha_next        = ccg_pkg::ALPHA_INIT;
                        window_next       = item.temperature;
                        fan_hold_next     = {1'b0, item.fan_now};
                        cap_factor        = ccg_pkg::CAP_CHANGE_INIT;
                        delta_next        = {30'd0, item.capacity_in, 2'b00};
                        period_timer_next = {16'd0, item.elapsed};
                        speed_timer_next  = (mode_reg == ccg_pkg::MODE_IDLE)
                                          ? ccg_pkg::sat_add32(ccg_pkg::SPEED_START,
                                                               item.elapsed)
                                          : {16'd0, item.elapsed};
                    end
                    else if (mode_reg == ccg_pkg::MODE_IDLE)
                    begin
                        mode_next         = ccg_pkg::MODE_STABLE;
                        trend_next        = ccg_pkg::TREND_NONE;
                        osc_next          = 2'd0;
                        watch_next        = 1'b0;
                        long_next         = 1'b0;
                        beta_next         = beta_settle;
                        delta_next        = '0;
                        fan_hold_next     = {1'b0, item.fan_now};
                        cap_factor        = ccg_pkg::CAP_UNITY - {2'b00, beta_settle};
                        period_timer_next = {16'd0, item.elapsed};
                    end
                    else
                    begin
                        period_timer_next = ccg_pkg::sat_add32(period_timer_reg, item.elapsed);
                        if (stable_hit)
                        begin
                            period_timer_next = {16'd0, item.elapsed};
                            if (item.temp_error <= ccg_pkg::TE_COLD)
                            begin
                                if (!watch_reg && (period_sel == cfg.speed_period))
                                    watch_next = 1'b1;
                                trend_next = ccg_pkg::TREND_UP;
                                beta_next  = beta_up;
                            end
                            else if ((item.temp_error >= ccg_pkg::TE_SETTLED) &&
                                     (beta_reg != 4'd0))
                            begin
                                if (watch_reg && (trend_reg == ccg_pkg::TREND_UP))
                                begin
                                    if (osc_inc >= 2'd2)
                                    begin
                                        long_next  = 1'b1;
                                        watch_next = 1'b0;
                                        osc_next   = 2'd0;
                                    end
                                    else
                                        osc_next = osc_inc;
                                end
                                trend_next = ccg_pkg::TREND_DOWN;
                                beta_next  = beta_dn;
                            end
                        end
                        fan_hold_next = {1'b0, item.fan_now};
                        cap_factor    = ccg_pkg::CAP_UNITY - {2'b00, beta_next};
                    end
                end
                ccg_pkg::MODE_CHANGE:
                begin
                    priority if ((!te_high && delta_le0) || te_settled)
                    begin
                        mode_next         = ccg_pkg::MODE_STABLE;
                        trend_next        = ccg_pkg::TREND_NONE;
                        osc_next          = 2'd0;
                        watch_next        = 1'b0;
                        long_next         = 1'b0;
                        beta_next         = beta_settle;
                        delta_next        = '0;
                        fan_hold_next     = {1'b0, item.fan_target};
                        cap_factor        = ccg_pkg::CAP_UNITY - {2'b00, beta_settle};
                        period_timer_next = {16'd0, item.elapsed};
                        speed_timer_next  = '0;
                    end
                    else if (delta_le0)
                    begin
                        raising_next      = 1'b0;
                        alpha_next        = ccg_pkg::ALPHA_INIT;
                        window_next       = item.temperature;
                        fan_hold_next     = {1'b0, item.fan_now};
                        cap_factor        = ccg_pkg::CAP_CHANGE_INIT;
                        delta_next        = {30'd0, item.capacity_in, 2'b00};
                        period_timer_next = {16'd0, item.elapsed};
                    end
                    else
                    begin
                        raising_next     = raise_new;
                        fan_hold_next    = speed_hit ? fan_boost : {1'b0, item.fan_now};
                        speed_timer_next = speed_hit ? {16'd0, item.elapsed}
                                         : ccg_pkg::sat_add32(speed_timer_reg, item.elapsed);
                        if (factor_hit)
                        begin
                            period_timer_next = {16'd0, item.elapsed};
                            window_next       = item.temperature;
                        end
                        else
                            period_timer_next = ccg_pkg::sat_add32(period_timer_reg,
                                                                   item.elapsed);
                        alpha_next = alpha_use;
                        cap_factor = raise_new ? ccg_pkg::CAP_UNITY + {3'b000, alpha_use}
                                               : ccg_pkg::CAP_UNITY - {3'b000, alpha_use};
                        delta_next = delta_sat;
                    end
                end
                default:
                begin
                    mode_next = ccg_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= ccg_pkg::MODE_IDLE;
            trend_reg        <= ccg_pkg::TREND_NONE;
            raising_reg      <= 1'b0;
            osc_reg          <= 2'd0;
            watch_reg        <= 1'b0;
            long_reg         <= 1'b0;
            period_timer_reg <= '0;
            speed_timer_reg  <= '0;
            window_reg       <= '0;
            alpha_reg        <= ccg_pkg::ALPHA_INIT;
            beta_reg         <= '0;
            delta_reg        <= '0;
            fan_hold_reg     <= '0;
            cap_hold_reg     <= '0;
        end
        else if (fire)
        begin
            mode_reg         <= mode_next;
            trend_reg        <= trend_next;
            raising_reg      <= raising_next;
            osc_reg          <= osc_next;
            watch_reg        <= watch_next;
            long_reg         <= long_next;
            period_timer_reg <= period_timer_next;
            speed_timer_reg  <= speed_timer_next;
            window_reg       <= window_next;
            alpha_reg        <= alpha_next;
            beta_reg         <= beta_next;
            delta_reg        <= delta_next;
            fan_hold_reg     <= fan_hold_next;
            cap_hold_reg     <= cap_hold_next;
        end
    end

    always_comb
    begin
        result.fan_out          = fan_hold_next;
        result.capacity_out_x40 = cap_hold_next;
        unique case (mode_next)
            ccg_pkg::MODE_IDLE:   result.mode_out = ccg_pkg::MODE_CODE_IDLE;
            ccg_pkg::MODE_STABLE: result.mode_out = ccg_pkg::MODE_CODE_STABLE;
            ccg_pkg::MODE_CHANGE: result.mode_out = ccg_pkg::MODE_CODE_CHANGE;
            default:              result.mode_out = ccg_pkg::MODE_CODE_IDLE;
        endcase
    end

endmodule

// File: design/cooling_capacity_governor.sv
// Top level of the cooling capacity governor: ports, registers and pipeline.
// One transaction is taken per cycle while the output side is not stalled.
// A sample passes through an input register (s1_item_reg), then the
// governor's state update and capacity trim run combinationally into the
// result register (out_data_reg). The rate is set by the state update loop
// in ccg_core, which each sample must close before the next one can use the
// state it leaves. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata; index 3 is ignored.
module cooling_capacity_governor
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ccg_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ccg_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);

    ccg_pkg::cfg_t      cfg_reg;
    ccg_pkg::in_item_t  s1_item_reg;
    logic               s1_valid_reg;
    ccg_pkg::out_item_t out_data_reg;
    logic               out_valid_reg;
    ccg_pkg::out_item_t core_result;
    logic               advance;
    logic               in_fire;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_period  <= ccg_pkg::SPEED_PERIOD_RST;
            cfg_reg.factor_period <= ccg_pkg::FACTOR_PERIOD_RST;
            cfg_reg.freq_limit    <= ccg_pkg::FREQ_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ccg_pkg::CFG_SPEED_PERIOD:  cfg_reg.speed_period  <= cfg_wdata;
                ccg_pkg::CFG_FACTOR_PERIOD: cfg_reg.factor_period <= cfg_wdata;
                ccg_pkg::CFG_FREQ_LIMIT:    cfg_reg.freq_limit    <= cfg_wdata[9:0];
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_item_reg <= in_data;
        if (advance)
            out_data_reg <= core_result;
    end

    ccg_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

`include "cooling_capacity_governor_assert.svh"

    `CCG_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid_reg && !s1_valid_reg, "pipeline not empty in reset")
    `CCG_ASSERT(a_stall_means_full, !in_ready |-> s1_valid_reg && out_valid_reg, "input stalled with room")
    `CCG_ASSERT(a_advance_fills_out, advance |=> out_valid_reg, "advanced transaction lost")
    `CCG_ASSERT(a_idle_fan_zero, out_valid_reg && (out_data_reg.mode_out == ccg_pkg::MODE_CODE_IDLE) |-> out_data_reg.fan_out == 11'd0, "idle result with nonzero fan")
    `CCG_ASSERT(a_stable_no_boost, out_valid_reg && (out_data_reg.mode_out == ccg_pkg::MODE_CODE_STABLE) |-> out_data_reg.fan_out[10] == 1'b0, "boosted fan in stable mode")

endmodule
